@@ src/signed_integer_alu_fold_defines.svh @@
// Assertion macros shared by the signed ALU fold RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SIGNED_INTEGER_ALU_FOLD_DEFINES_SVH
`define SIGNED_INTEGER_ALU_FOLD_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define SIF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset.
`define SIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sif_pkg.sv @@
// Package for the signed ALU fold: opcodes, result select codes, control struct.
// No dependencies.
`timescale 1ns / 1ps
package sif_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int OUT_WIDTH      = 64;
  localparam int CMD_WIDTH      = 4;

  localparam logic [CMD_WIDTH-1:0] CMD_ADD = 4'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_SUB = 4'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_MUL = 4'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_DIV = 4'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_MOD = 4'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_EQ  = 4'd5;
  localparam logic [CMD_WIDTH-1:0] CMD_NE  = 4'd6;
  localparam logic [CMD_WIDTH-1:0] CMD_LT  = 4'd7;
  localparam logic [CMD_WIDTH-1:0] CMD_LE  = 4'd8;
  localparam logic [CMD_WIDTH-1:0] CMD_GT  = 4'd9;
  localparam logic [CMD_WIDTH-1:0] CMD_GE  = 4'd10;

  typedef enum logic [1:0] {
    SEL_AUX = 2'd0,
    SEL_MUL = 2'd1,
    SEL_DIV = 2'd2,
    SEL_MOD = 2'd3
  } sel_t;

  typedef struct packed {
    logic valid;
    logic fold;
    logic is_bool;
    logic bval;
    sel_t sel;
    logic neg_q;
    logic neg_r;
  } ctrl_t;

endpackage

@@ src/sif_cell.sv @@
// One cell of the fold chain: one restoring divide step and one shift-add step.
// Depends on sif_pkg.
`timescale 1ns / 1ps
module sif_cell
  import sif_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF,
  parameter int K = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  ctrl_t        ctrl_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] dvd_i,
  input  logic [W-1:0] dvs_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] mcand_i,
  input  logic [W-1:0] mplier_i,
  input  logic [W-1:0] prod_i,
  input  logic [W-1:0] aux_i,
  output ctrl_t        ctrl_r,
  output logic [W-1:0] rem_r,
  output logic [W-1:0] dvd_r,
  output logic [W-1:0] dvs_r,
  output logic [W-1:0] quo_r,
  output logic [W-1:0] mcand_r,
  output logic [W-1:0] mplier_r,
  output logic [W-1:0] prod_r,
  output logic [W-1:0] aux_r
);

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;
  logic [W-1:0] prod_nxt;

  // Bring down one dividend bit, trial-subtract, keep on no borrow.
  always_comb begin
    rem_sh   = {rem_i, dvd_i[W-1-K]};
    diff     = rem_sh - {1'b0, dvs_i};
    rem_nxt  = diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
    quo_nxt  = quo_i;
    quo_nxt[W-1-K] = ~diff[W];
    prod_nxt = mplier_i[K] ? (prod_i + (mcand_i << K)) : prod_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (adv) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r    <= rem_nxt;
      dvd_r    <= dvd_i;
      dvs_r    <= dvs_i;
      quo_r    <= quo_nxt;
      mcand_r  <= mcand_i;
      mplier_r <= mplier_i;
      prod_r   <= prod_nxt;
      aux_r    <= aux_i;
    end
  end

endmodule

@@ src/signed_integer_alu_fold.sv @@
// Pipeline: a front register, a row of DATA_WIDTH cells and an output register.
// Throughput: one instruction per cycle while no result is stalled; a row of
// DATA_WIDTH cells each take a quotient and a multiplier bit; no unit is shared.
// The whole row advances together; a stalled result holds every stage.
// Reset: synchronous active-low rst_n clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`include "signed_integer_alu_fold_defines.svh"
module signed_integer_alu_fold
  import sif_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [CMD_WIDTH-1:0]        in_command,
  input  logic signed [OUT_WIDTH-1:0] in_operand_a,
  input  logic signed [OUT_WIDTH-1:0] in_operand_b,
  input  logic                        in_both_constant,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_folded,
  output logic                        out_is_boolean,
  output logic signed [OUT_WIDTH-1:0] out_int_result,
  output logic                        out_bool_result
);

  localparam int W = DATA_WIDTH;

  // Chain taps: index 0 is the front register, index W the last cell.
  ctrl_t        ctrl_s   [0:W];
  logic [W-1:0] rem_s    [0:W];
  logic [W-1:0] dvd_s    [0:W];
  logic [W-1:0] dvs_s    [0:W];
  logic [W-1:0] quo_s    [0:W];
  logic [W-1:0] mcand_s  [0:W];
  logic [W-1:0] mplier_s [0:W];
  logic [W-1:0] prod_s   [0:W];
  logic [W-1:0] aux_s    [0:W];

  logic adv;

  // Front-stage decode
  logic [W-1:0] a_w;
  logic [W-1:0] b_w;
  logic         lt_ab;
  logic         lt_ba;
  logic         eq_ab;
  ctrl_t        ctrl_nxt;
  logic [W-1:0] aux_nxt;

  // Output stage
  logic                 out_valid_r;
  logic                 out_folded_r;
  logic                 out_is_boolean_r;
  logic [OUT_WIDTH-1:0] out_int_result_r;
  logic                 out_bool_result_r;
  logic [W-1:0]         res_w;
  logic [OUT_WIDTH-1:0] out_int_result_nxt;

  // Advance the whole row unless a finished result is held by the sink.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Use only the low DATA_WIDTH bits of each operand.
  assign a_w   = in_operand_a[W-1:0];
  assign b_w   = in_operand_b[W-1:0];
  assign eq_ab = (a_w == b_w);
  assign lt_ab = ($signed(a_w) < $signed(b_w));
  assign lt_ba = ($signed(b_w) < $signed(a_w));

  // Settle comparisons, add and subtract here; flag which result to take later.
  always_comb begin
    ctrl_nxt         = '0;
    ctrl_nxt.valid   = in_valid;
    ctrl_nxt.neg_q   = a_w[W-1] ^ b_w[W-1];
    ctrl_nxt.neg_r   = a_w[W-1];
    ctrl_nxt.sel     = SEL_AUX;
    aux_nxt          = '0;
    case (in_command)
      CMD_ADD: begin
        ctrl_nxt.fold = 1'b1;
        aux_nxt       = a_w + b_w;
      end
      CMD_SUB: begin
        ctrl_nxt.fold = 1'b1;
        aux_nxt       = a_w - b_w;
      end
      CMD_MUL: begin
        ctrl_nxt.fold = 1'b1;
        ctrl_nxt.sel  = SEL_MUL;
      end
      CMD_DIV: begin
        ctrl_nxt.fold = (b_w != '0);
        ctrl_nxt.sel  = SEL_DIV;
      end
      CMD_MOD: begin
        ctrl_nxt.fold = (b_w != '0);
        ctrl_nxt.sel  = SEL_MOD;
      end
      CMD_EQ: begin
        ctrl_nxt.fold = 1'b1; ctrl_nxt.is_bool = 1'b1; ctrl_nxt.bval = eq_ab;
      end
      CMD_NE: begin
        ctrl_nxt.fold = 1'b1; ctrl_nxt.is_bool = 1'b1; ctrl_nxt.bval = !eq_ab;
      end
      CMD_LT: begin
        ctrl_nxt.fold = 1'b1; ctrl_nxt.is_bool = 1'b1; ctrl_nxt.bval = lt_ab;
      end
      CMD_LE: begin
        ctrl_nxt.fold = 1'b1; ctrl_nxt.is_bool = 1'b1; ctrl_nxt.bval = !lt_ba;
      end
      CMD_GT: begin
        ctrl_nxt.fold = 1'b1; ctrl_nxt.is_bool = 1'b1; ctrl_nxt.bval = lt_ba;
      end
      CMD_GE: begin
        ctrl_nxt.fold = 1'b1; ctrl_nxt.is_bool = 1'b1; ctrl_nxt.bval = !lt_ab;
      end
      default: begin
        ctrl_nxt.fold = 1'b0;
      end
    endcase
    // Drop the fold and boolean flags when the operands are not both constant.
    if (!in_both_constant) begin
      ctrl_nxt.fold    = 1'b0;
      ctrl_nxt.is_bool = 1'b0;
      ctrl_nxt.bval    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_s[0] <= '0;
    end else if (adv) begin
      ctrl_s[0] <= ctrl_nxt;
    end
  end

  // Front register: magnitudes feed the divider, raw words feed the multiplier.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s[0]    <= '0;
      dvd_s[0]    <= a_w[W-1] ? -a_w : a_w;
      dvs_s[0]    <= b_w[W-1] ? -b_w : b_w;
      quo_s[0]    <= '0;
      mcand_s[0]  <= a_w;
      mplier_s[0] <= b_w;
      prod_s[0]   <= '0;
      aux_s[0]    <= aux_nxt;
    end
  end

  // Row of cells: cell k resolves quotient bit W-1-k and multiplier bit k.
  for (genvar k = 0; k < W; k++) begin : g_cell
    sif_cell #(
      .W (W),
      .K (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .ctrl_i   (ctrl_s[k]),
      .rem_i    (rem_s[k]),
      .dvd_i    (dvd_s[k]),
      .dvs_i    (dvs_s[k]),
      .quo_i    (quo_s[k]),
      .mcand_i  (mcand_s[k]),
      .mplier_i (mplier_s[k]),
      .prod_i   (prod_s[k]),
      .aux_i    (aux_s[k]),
      .ctrl_r   (ctrl_s[k+1]),
      .rem_r    (rem_s[k+1]),
      .dvd_r    (dvd_s[k+1]),
      .dvs_r    (dvs_s[k+1]),
      .quo_r    (quo_s[k+1]),
      .mcand_r  (mcand_s[k+1]),
      .mplier_r (mplier_s[k+1]),
      .prod_r   (prod_s[k+1]),
      .aux_r    (aux_s[k+1])
    );
  end

  // Apply signs to quotient and remainder, pick the result, sign-extend; zero if unfolded or boolean.
  always_comb begin
    case (ctrl_s[W].sel)
      SEL_MUL: res_w = prod_s[W];
      SEL_DIV: res_w = ctrl_s[W].neg_q ? -quo_s[W] : quo_s[W];
      SEL_MOD: res_w = ctrl_s[W].neg_r ? -rem_s[W] : rem_s[W];
      default: res_w = aux_s[W];
    endcase
    if (!ctrl_s[W].fold || ctrl_s[W].is_bool) begin
      out_int_result_nxt = '0;
    end else begin
      out_int_result_nxt = OUT_WIDTH'($signed(res_w));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctrl_s[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_folded_r      <= ctrl_s[W].fold;
      out_is_boolean_r  <= ctrl_s[W].is_bool;
      out_bool_result_r <= ctrl_s[W].bval;
      out_int_result_r  <= out_int_result_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_folded      = out_folded_r;
  assign out_is_boolean  = out_is_boolean_r;
  assign out_int_result  = out_int_result_r;
  assign out_bool_result = out_bool_result_r;

  `SIF_ASSERT_NOW(a_nofold_zero, out_valid && !out_folded,
    (out_int_result == '0) && !out_bool_result && !out_is_boolean,
    "unfolded result carries nonzero fields")
  `SIF_ASSERT_NOW(a_bool_no_int, out_valid && out_is_boolean, out_int_result == '0,
    "boolean result carries an integer value")
  `SIF_ASSERT_NEXT(a_row_holds, in_stall, $stable(ctrl_s[W]) && out_valid,
    "row moved while the result was held")

endmodule
